// File: hw/rtl/stdp_weight_update_defines.svh
// Assertion macros shared by the STDP weight update RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef STDP_WEIGHT_UPDATE_DEFINES_SVH
`define STDP_WEIGHT_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STDP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stdp_pkg.sv
// Package for the STDP weight update block: widths, request and result types,
// action and register codes, and small helper functions. No dependencies.
`default_nettype none

package stdp_pkg;

  localparam int HISTORY_BITS   = 64;
  localparam int WEIGHT_BITS    = 32;
  localparam int TABLE_DEPTH    = 64;
  localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
  localparam int HIST_AW        = $clog2(HISTORY_BITS);
  localparam int WIN_BITS       = 7;
  localparam int WIN_MAX        = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [1:0] ACT_LOAD_PRE  = 2'd0;
  localparam logic [1:0] ACT_LOAD_POST = 2'd1;
  localparam logic [1:0] ACT_EVAL      = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POT_MASK = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEP_MASK = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRE_POST = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POST_PRE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_EXC  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_EXC  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_INH  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_INH  = 3'd7;

  typedef logic [HISTORY_BITS-1:0]       hist_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [WEIGHT_BITS:0]   wide_t;
  typedef logic [WIN_BITS-1:0]           win_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [TABLE_AW-1:0] table_index;
    weight_t             table_value;
    hist_t               firing_history;
    weight_t             old_weight;
    weight_t             pending_change;
  } stdp_in_t;

  typedef struct packed {
    weight_t weight_change;
    weight_t new_weight;
  } stdp_out_t;

  typedef struct packed {
    logic                hit;
    logic                use_pre;
    logic [TABLE_AW-1:0] idx;
  } dist_sel_t;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_POS,
    WS_NEG
  } wsign_t;

  function automatic win_t clamp_window(win_t w);
    return (w > win_t'(WIN_MAX)) ? win_t'(WIN_MAX) : w;
  endfunction

  function automatic hist_t low_ones(win_t n);
    if (n >= win_t'(HISTORY_BITS)) begin
      return '1;
    end
    return (hist_t'(1) << n) - hist_t'(1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stdp_weight_update.sv
// Pipeline: a request passes through the stage 1, 2 and 3 registers and then the output register.
// Throughput: one request per cycle; the whole pipeline moves whenever the output
// register is empty or being taken, and the two tables each serve both regions.
// Reset clears configuration registers and pipeline valid bits; table contents
// are not cleared and must be loaded before they are used.
`default_nettype none

`include "stdp_weight_update_defines.svh"

module stdp_weight_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [stdp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stdp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stdp_pkg::stdp_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stdp_pkg::stdp_out_t                 out_data
);
  import stdp_pkg::*;

  hist_t   cfg_pot_mask_r;
  hist_t   cfg_dep_mask_r;
  win_t    cfg_pre_post_r;
  win_t    cfg_post_pre_r;
  weight_t cfg_min_exc_r;
  weight_t cfg_max_exc_r;
  weight_t cfg_min_inh_r;
  weight_t cfg_max_inh_r;

  logic advance;
  win_t pw;
  win_t rw;
  hist_t pre_bits;
  hist_t post_bits;
  hist_t pot_hist;
  hist_t dep_hist;

  logic                s1_valid_r;
  logic [1:0]          s1_act_r;
  logic [TABLE_AW-1:0] s1_idx_r;
  weight_t             s1_val_r;
  hist_t               s1_pot_pre_r;
  hist_t               s1_pot_post_r;
  hist_t               s1_dep_pre_r;
  hist_t               s1_dep_post_r;
  weight_t             s1_old_r;
  weight_t             s1_pend_r;

  dist_sel_t           pot_sel_nxt;
  dist_sel_t           dep_sel_nxt;
  wide_t               sum_nxt;
  wsign_t              sign_nxt;

  logic                s2_valid_r;
  logic [1:0]          s2_act_r;
  logic [TABLE_AW-1:0] s2_idx_r;
  weight_t             s2_val_r;
  dist_sel_t           s2_pot_sel_r;
  dist_sel_t           s2_dep_sel_r;
  wide_t               s2_sum_r;
  wsign_t              s2_sign_r;

  weight_t             lo_sel;
  weight_t             hi_sel;
  wide_t               lo_wide;
  wide_t               lomax_nxt;
  weight_t             pre_rd_pot;
  weight_t             pre_rd_dep;
  weight_t             post_rd_pot;
  weight_t             post_rd_dep;

  logic                s3_valid_r;
  logic [1:0]          s3_act_r;
  dist_sel_t           s3_pot_sel_r;
  dist_sel_t           s3_dep_sel_r;
  wsign_t              s3_sign_r;
  wide_t               s3_lomax_r;
  weight_t             s3_hi_r;

  weight_t             pot_val;
  weight_t             dep_val;
  wide_t               change_sum;
  wide_t               hi_wide;
  wide_t               clamp_wide;
  stdp_out_t           out_data_nxt;

  logic                out_valid_r;
  stdp_out_t           out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pot_mask_r <= '0;
      cfg_dep_mask_r <= '0;
      cfg_pre_post_r <= '0;
      cfg_post_pre_r <= '0;
      cfg_min_exc_r  <= '0;
      cfg_max_exc_r  <= '0;
      cfg_min_inh_r  <= '0;
      cfg_max_inh_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POT_MASK: cfg_pot_mask_r <= cfg_data[HISTORY_BITS-1:0];
        CFG_DEP_MASK: cfg_dep_mask_r <= cfg_data[HISTORY_BITS-1:0];
        CFG_PRE_POST: cfg_pre_post_r <= cfg_data[WIN_BITS-1:0];
        CFG_POST_PRE: cfg_post_pre_r <= cfg_data[WIN_BITS-1:0];
        CFG_MIN_EXC:  cfg_min_exc_r  <= cfg_data[WEIGHT_BITS-1:0];
        CFG_MAX_EXC:  cfg_max_exc_r  <= cfg_data[WEIGHT_BITS-1:0];
        CFG_MIN_INH:  cfg_min_inh_r  <= cfg_data[WEIGHT_BITS-1:0];
        CFG_MAX_INH:  cfg_max_inh_r  <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Stage 1: window masks and region masking.
  assign pw        = clamp_window(cfg_post_pre_r);
  assign rw        = clamp_window(cfg_pre_post_r);
  assign pre_bits  = (pw >= win_t'(HISTORY_BITS)) ? '0 : (low_ones(rw) << pw[HIST_AW-1:0]);
  assign post_bits = low_ones(pw);
  assign pot_hist  = in_data.firing_history & cfg_pot_mask_r;
  assign dep_hist  = in_data.firing_history & cfg_dep_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_act_r      <= in_data.action;
      s1_idx_r      <= in_data.table_index;
      s1_val_r      <= in_data.table_value;
      s1_pot_pre_r  <= pot_hist & pre_bits;
      s1_pot_post_r <= pot_hist & post_bits;
      s1_dep_pre_r  <= dep_hist & pre_bits;
      s1_dep_post_r <= dep_hist & post_bits;
      s1_old_r      <= in_data.old_weight;
      s1_pend_r     <= in_data.pending_change;
    end
  end

  // Stage 2: distance search and weight sum.
  stdp_dist u_dist_pot (
    .pre_v  (s1_pot_pre_r),
    .post_v (s1_pot_post_r),
    .pw     (pw),
    .sel    (pot_sel_nxt)
  );

  stdp_dist u_dist_dep (
    .pre_v  (s1_dep_pre_r),
    .post_v (s1_dep_post_r),
    .pw     (pw),
    .sel    (dep_sel_nxt)
  );

  assign sum_nxt = {s1_old_r[WEIGHT_BITS-1], s1_old_r} + {s1_pend_r[WEIGHT_BITS-1], s1_pend_r};

  always_comb begin
    if (s1_old_r == '0) begin
      sign_nxt = WS_ZERO;
    end else if (s1_old_r[WEIGHT_BITS-1]) begin
      sign_nxt = WS_NEG;
    end else begin
      sign_nxt = WS_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_act_r     <= s1_act_r;
      s2_idx_r     <= s1_idx_r;
      s2_val_r     <= s1_val_r;
      s2_pot_sel_r <= pot_sel_nxt;
      s2_dep_sel_r <= dep_sel_nxt;
      s2_sum_r     <= sum_nxt;
      s2_sign_r    <= sign_nxt;
    end
  end

  // Stage 3: table access and lower clamp. Loads write here so that they stay
  // in order with the lookups of neighboring requests.
  stdp_table u_pre_table (
    .clk     (clk),
    .en      (advance),
    .we      (s2_valid_r && (s2_act_r == ACT_LOAD_PRE)),
    .waddr   (s2_idx_r),
    .wdata   (s2_val_r),
    .raddr_a (s2_pot_sel_r.idx),
    .raddr_b (s2_dep_sel_r.idx),
    .rdata_a (pre_rd_pot),
    .rdata_b (pre_rd_dep)
  );

  stdp_table u_post_table (
    .clk     (clk),
    .en      (advance),
    .we      (s2_valid_r && (s2_act_r == ACT_LOAD_POST)),
    .waddr   (s2_idx_r),
    .wdata   (s2_val_r),
    .raddr_a (s2_pot_sel_r.idx),
    .raddr_b (s2_dep_sel_r.idx),
    .rdata_a (post_rd_pot),
    .rdata_b (post_rd_dep)
  );

  assign lo_sel    = (s2_sign_r == WS_NEG) ? cfg_max_inh_r : cfg_min_exc_r;
  assign hi_sel    = (s2_sign_r == WS_NEG) ? cfg_min_inh_r : cfg_max_exc_r;
  assign lo_wide   = {lo_sel[WEIGHT_BITS-1], lo_sel};
  assign lomax_nxt = (s2_sum_r > lo_wide) ? s2_sum_r : lo_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_act_r     <= s2_act_r;
      s3_pot_sel_r <= s2_pot_sel_r;
      s3_dep_sel_r <= s2_dep_sel_r;
      s3_sign_r    <= s2_sign_r;
      s3_lomax_r   <= lomax_nxt;
      s3_hi_r      <= hi_sel;
    end
  end

  // Stage 4: saturating change sum, upper clamp and output register.
  assign pot_val = !s3_pot_sel_r.hit ? '0 : (s3_pot_sel_r.use_pre ? pre_rd_pot : post_rd_pot);
  assign dep_val = !s3_dep_sel_r.hit ? '0 : (s3_dep_sel_r.use_pre ? pre_rd_dep : post_rd_dep);
  assign change_sum = {pot_val[WEIGHT_BITS-1], pot_val} + {dep_val[WEIGHT_BITS-1], dep_val};
  assign hi_wide    = {s3_hi_r[WEIGHT_BITS-1], s3_hi_r};
  assign clamp_wide = (s3_lomax_r < hi_wide) ? s3_lomax_r : hi_wide;

  always_comb begin
    if (change_sum[WEIGHT_BITS] != change_sum[WEIGHT_BITS-1]) begin
      out_data_nxt.weight_change = change_sum[WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS-1){1'b0}}}
                                                           : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    end else begin
      out_data_nxt.weight_change = change_sum[WEIGHT_BITS-1:0];
    end
    if (s3_sign_r == WS_ZERO) begin
      out_data_nxt.new_weight = '0;
    end else begin
      out_data_nxt.new_weight = clamp_wide[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r && (s3_act_r == ACT_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STDP_ASSERT_NEXT(a_stall_holds_s1, s1_valid_r && !advance,
                    s1_valid_r && $stable(s1_act_r) && $stable(s1_pot_pre_r),
                    "Stage 1 changed while the pipeline was stalled.")
  `STDP_ASSERT_NEXT(a_load_gives_no_result, advance && s3_valid_r && (s3_act_r != ACT_EVAL),
                    !out_valid_r, "A table load produced a result.")
  `STDP_ASSERT_NEXT(a_bubble_gives_no_result, advance && !s3_valid_r,
                    !out_valid_r, "A result appeared without a request.")
  `STDP_ASSERT_NEXT(a_zero_weight_stays_zero,
                    advance && s3_valid_r && (s3_act_r == ACT_EVAL) && (s3_sign_r == WS_ZERO),
                    out_valid_r && (out_data_r.new_weight == '0),
                    "A zero weight was updated to a nonzero value.")
  `STDP_ASSERT_SAME(a_pre_select_needs_hit, s2_valid_r && s2_pot_sel_r.use_pre,
                    s2_pot_sel_r.hit, "Pre table selected for a region without a hit.")

endmodule

`default_nettype wire

// File: hw/rtl/stdp_dist.sv
// Finds the pre-fire and post-fire distances of one masked history region and
// picks the nearer table entry; a tie gives no hit. Depends on stdp_pkg.
`default_nettype none

module stdp_dist (
  input  stdp_pkg::hist_t     pre_v,
  input  stdp_pkg::hist_t     post_v,
  input  stdp_pkg::win_t      pw,
  output stdp_pkg::dist_sel_t sel
);
  import stdp_pkg::*;

  hist_t               pre_low;
  hist_t               post_rev;
  hist_t               post_low;
  logic [HIST_AW-1:0]  lo_pos;
  logic [HIST_AW-1:0]  rev_pos;
  logic [HIST_AW-1:0]  hi_pos;
  win_t                dt_pre_w;
  win_t                dt_post_w;
  logic [TABLE_AW-1:0] dt_pre;
  logic [TABLE_AW-1:0] dt_post;
  logic                has_pre;
  logic                has_post;
  logic                hit_pre;
  logic                hit_post;

  always_comb begin
    for (int i = 0; i < HISTORY_BITS; i++) begin
      post_rev[i] = post_v[HISTORY_BITS-1-i];
    end
  end

  assign pre_low  = pre_v & (~pre_v + hist_t'(1));
  assign post_low = post_rev & (~post_rev + hist_t'(1));

  always_comb begin
    lo_pos  = '0;
    rev_pos = '0;
    for (int i = 0; i < HISTORY_BITS; i++) begin
      lo_pos  = lo_pos  | (pre_low[i]  ? HIST_AW'(i) : '0);
      rev_pos = rev_pos | (post_low[i] ? HIST_AW'(i) : '0);
    end
  end

  assign hi_pos    = HIST_AW'(HISTORY_BITS - 1) - rev_pos;
  assign has_pre   = |pre_v;
  assign has_post  = |post_v;
  assign dt_pre_w  = win_t'(lo_pos) - pw;
  assign dt_post_w = pw - win_t'(1) - win_t'(hi_pos);
  assign dt_pre    = dt_pre_w[TABLE_AW-1:0];
  assign dt_post   = dt_post_w[TABLE_AW-1:0];
  assign hit_pre   = has_pre && (!has_post || (dt_pre < dt_post));
  assign hit_post  = has_post && (!has_pre || (dt_post < dt_pre));

  assign sel.hit     = hit_pre || hit_post;
  assign sel.use_pre = hit_pre;
  assign sel.idx     = hit_pre ? dt_pre : dt_post;

endmodule

`default_nettype wire

// File: hw/rtl/stdp_table.sv
// One 64-entry delta table with one write port and two registered read ports.
// Depends on stdp_pkg.
`default_nettype none

module stdp_table (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [stdp_pkg::TABLE_AW-1:0] waddr,
  input  stdp_pkg::weight_t             wdata,
  input  logic [stdp_pkg::TABLE_AW-1:0] raddr_a,
  input  logic [stdp_pkg::TABLE_AW-1:0] raddr_b,
  output stdp_pkg::weight_t             rdata_a,
  output stdp_pkg::weight_t             rdata_b
);
  import stdp_pkg::*;

  weight_t mem [TABLE_DEPTH];
  weight_t rdata_a_r;
  weight_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire
